// ----- rtl/tcp_pkg.sv -----
`timescale 1ns / 1ps
package tcp_pkg;

  localparam int DISP_WIDTH  = 800;
  localparam int DISP_HEIGHT = 600;
  localparam int RAW_WIDTH   = 800;
  localparam int Y_BIAS      = 0;

  localparam logic [31:0] RAW_WIDTH_W = 32'(RAW_WIDTH);
  localparam logic [31:0] Y_BIAS_W    = 32'(Y_BIAS);

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  localparam logic [15:0] CODE_X         = 16'h0000;
  localparam logic [15:0] CODE_Y         = 16'h0001;
  localparam logic [15:0] CODE_MT_X      = 16'h0035;
  localparam logic [15:0] CODE_MT_Y      = 16'h0036;
  localparam logic [15:0] CODE_BTN_MOUSE = 16'h0110;
  localparam logic [15:0] CODE_BTN_TOUCH = 16'h014A;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_270  = 2'd2;

  localparam logic [1:0] DEV_POINTER = 2'd0;
  localparam logic [1:0] DEV_KEYPAD  = 2'd1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE   = 3'd6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int MAG_W          = 48;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = MAG_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [15:0]        x_low;
    logic [15:0]        x_high;
    logic [15:0]        y_low;
    logic [15:0]        y_high;
    logic signed [15:0] shift;
    logic [1:0]         rotation;
    logic [1:0]         device_kind;
  } cfg_t;

  typedef struct packed {
    logic        is_keypad;
    logic        pressed;
    logic [7:0]  key_code;
    logic [31:0] px;
    logic [31:0] py;
    logic        cal;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIX,
    BK_LOAD
  } back_state_t;

endpackage

// ----- rtl/tcp_front.sv -----
`timescale 1ns / 1ps
module tcp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  tcp_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [15:0]        in_ev_type,
  input  logic [15:0]        in_ev_code,
  input  logic signed [31:0] in_ev_value,
  input  tcp_pkg::q_status_t q_status,
  output logic               q_push,
  output tcp_pkg::job_t      q_job
);
  import tcp_pkg::*;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [7:0] key_map(input logic [15:0] code);
    logic [7:0] k;
    unique case (code)
      16'd14:  k = 8'd8;
      16'd28:  k = 8'd10;
      16'd103: k = 8'd17;
      16'd105: k = 8'd11;
      16'd106: k = 8'd9;
      16'd108: k = 8'd18;
      default: k = 8'd0;
    endcase
    return k;
  endfunction

  logic [31:0] pos_x_r, pos_x_nxt;
  logic [31:0] pos_y_r, pos_y_nxt;
  logic        button_r, button_nxt;
  logic [7:0]  last_key_r, last_key_nxt;

  logic        accept;
  logic [31:0] val_u;
  logic [31:0] y_in;
  logic [31:0] rot_y90;
  logic        cal_on;
  logic        is_btn;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign val_u    = $unsigned(in_ev_value);
  assign y_in     = abs32(val_u + Y_BIAS_W);
  assign rot_y90  = abs32(RAW_WIDTH_W - pos_x_r);
  assign cal_on   = (cfg.x_low != 16'd0) && (cfg.x_high != 16'd0) &&
                    (cfg.y_low != 16'd0) && (cfg.y_high != 16'd0);
  assign is_btn   = (in_ev_code == CODE_BTN_MOUSE) || (in_ev_code == CODE_BTN_TOUCH);

  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    button_nxt   = button_r;
    last_key_nxt = last_key_r;
    q_push       = 1'b0;
    q_job        = '0;
    if (accept) begin
      if (in_func == FUNC_EVENT) begin
        case (in_ev_type)
          EV_REL: begin
            if (in_ev_code == CODE_X) begin
              pos_x_nxt = pos_x_r + val_u;
            end else if (in_ev_code == CODE_Y) begin
              pos_y_nxt = pos_y_r + y_in;
            end
          end
          EV_ABS: begin
            if ((in_ev_code == CODE_X) || (in_ev_code == CODE_MT_X)) begin
              pos_x_nxt = val_u;
            end else if ((in_ev_code == CODE_Y) || (in_ev_code == CODE_MT_Y)) begin
              pos_y_nxt = y_in;
            end
          end
          EV_KEY: begin
            if (is_btn) begin
              if (val_u == 32'd0) begin
                button_nxt = 1'b0;
              end else if (val_u == 32'd1) begin
                button_nxt = 1'b1;
              end
            end else if (cfg.device_kind == DEV_KEYPAD) begin
              button_nxt        = (val_u != 32'd0);
              last_key_nxt      = key_map(in_ev_code);
              q_push            = 1'b1;
              q_job.is_keypad   = 1'b1;
              q_job.pressed     = (val_u != 32'd0);
              q_job.key_code    = key_map(in_ev_code);
            end
          end
          default: ;
        endcase
      end else begin
        if (cfg.device_kind == DEV_KEYPAD) begin
          q_push          = 1'b1;
          q_job.is_keypad = 1'b1;
          q_job.pressed   = button_r;
          q_job.key_code  = last_key_r;
        end else if (cfg.device_kind == DEV_POINTER) begin
          q_push        = 1'b1;
          q_job.pressed = button_r;
          q_job.cal     = cal_on;
          if (cfg.rotation == ROT_90) begin
            q_job.px = pos_y_r;
            q_job.py = rot_y90;
          end else if (cfg.rotation == ROT_270) begin
            q_job.px = pos_y_r;
            q_job.py = pos_x_r;
          end else begin
            q_job.px = pos_x_r;
            q_job.py = pos_y_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      button_r   <= 1'b0;
      last_key_r <= '0;
    end else begin
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      button_r   <= button_nxt;
      last_key_r <= last_key_nxt;
    end
  end

endmodule

// ----- rtl/tcp_fifo.sv -----
`timescale 1ns / 1ps
module tcp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tcp_pkg::job_t      push_job,
  input  logic               pop,
  output tcp_pkg::job_t      head,
  output tcp_pkg::q_status_t status
);
  import tcp_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/tcp_back.sv -----
`timescale 1ns / 1ps
module tcp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tcp_pkg::cfg_t      cfg,
  input  tcp_pkg::job_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_keypad,
  output logic               out_pressed,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [7:0]         out_key_code
);
  import tcp_pkg::*;

  back_state_t          state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic                 axis_r, axis_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [16:0]          rem_r, rem_nxt;
  logic [15:0]          den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          res_x_r, res_x_nxt;
  logic [31:0]          res_y_r, res_y_nxt;

  logic                 ov_r, ov_nxt;
  logic                 o_keypad_r, o_keypad_nxt;
  logic                 o_pressed_r, o_pressed_nxt;
  logic [31:0]          o_x_r, o_x_nxt;
  logic [31:0]          o_y_r, o_y_nxt;
  logic [7:0]           o_key_r, o_key_nxt;

  logic                 out_free;
  logic signed [17:0]   shift18;
  logic signed [17:0]   y_lo_s;
  logic signed [32:0]   a_op;
  logic signed [17:0]   b_op;
  logic signed [16:0]   den_op;
  logic [32:0]          a_mag;
  logic [16:0]          b_mag;
  logic [16:0]          den_mag;
  logic [49:0]          prod;
  logic [16:0]          rem_t;
  logic [16:0]          rem_sh;
  logic [MAG_W-1:0]     mag_t;
  logic signed [49:0]   q_s;
  logic signed [49:0]   lo_s;
  logic signed [49:0]   v_s;
  logic signed [49:0]   size_s;
  logic [31:0]          clamped;

  assign out_free = !ov_r || !out_stall;
  assign shift18  = $signed({{2{cfg.shift[15]}}, cfg.shift});
  assign y_lo_s   = $signed({2'b00, cfg.y_low}) + shift18;

  // operands of the mapping for the current axis
  always_comb begin
    if (!axis_r) begin
      a_op   = $signed({job_r.px[31], job_r.px}) - $signed({17'd0, cfg.x_low});
      b_op   = $signed(18'(DISP_WIDTH)) - shift18;
      den_op = $signed({1'b0, cfg.x_high}) - $signed({1'b0, cfg.x_low});
    end else begin
      a_op   = $signed({job_r.py[31], job_r.py}) - $signed({{15{y_lo_s[17]}}, y_lo_s});
      b_op   = $signed(18'(DISP_HEIGHT));
      den_op = $signed({1'b0, cfg.y_high}) - $signed({1'b0, cfg.y_low});
    end
    a_mag   = a_op[32] ? (33'd0 - $unsigned(a_op)) : $unsigned(a_op);
    b_mag   = b_op[17] ? 17'(18'd0 - $unsigned(b_op)) : 17'($unsigned(b_op));
    den_mag = den_op[16] ? (17'd0 - $unsigned(den_op)) : $unsigned(den_op);
    prod    = {17'd0, a_mag} * {33'd0, b_mag};
  end

  // restoring division, DIV_RADIX_BITS quotient bits per cycle
  always_comb begin
    rem_t  = rem_r;
    mag_t  = mag_r;
    rem_sh = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      rem_sh = {rem_t[15:0], mag_t[MAG_W-1]};
      mag_t  = {mag_t[MAG_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem_t    = rem_sh - {1'b0, den_r};
        mag_t[0] = 1'b1;
      end else begin
        rem_t = rem_sh;
      end
    end
  end

  // sign, offset and clamp
  always_comb begin
    q_s    = $signed({2'b00, mag_r});
    if (neg_r) begin
      q_s = -q_s;
    end
    lo_s   = axis_r ? '0 : $signed({{34{cfg.shift[15]}}, cfg.shift});
    v_s    = zero_r ? lo_s : (q_s + lo_s);
    size_s = axis_r ? $signed(50'(DISP_HEIGHT)) : $signed(50'(DISP_WIDTH));
    if (v_s[49]) begin
      clamped = '0;
    end else if (v_s >= size_s) begin
      clamped = 32'(size_s - 50'sd1);
    end else begin
      clamped = v_s[31:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    axis_nxt      = axis_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    cnt_nxt       = cnt_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    ov_nxt        = ov_r && out_stall;
    o_keypad_nxt  = o_keypad_r;
    o_pressed_nxt = o_pressed_r;
    o_x_nxt       = o_x_r;
    o_y_nxt       = o_y_r;
    o_key_nxt     = o_key_r;
    q_pop         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.cal) begin
            q_pop     = 1'b1;
            job_nxt   = q_head;
            axis_nxt  = 1'b0;
            state_nxt = BK_MUL;
          end else if (out_free) begin
            q_pop         = 1'b1;
            ov_nxt        = 1'b1;
            o_keypad_nxt  = q_head.is_keypad;
            o_pressed_nxt = q_head.pressed;
            o_x_nxt       = q_head.px;
            o_y_nxt       = q_head.py;
            o_key_nxt     = q_head.key_code;
          end
        end
      end
      BK_MUL: begin
        mag_nxt   = prod[MAG_W-1:0];
        rem_nxt   = '0;
        den_nxt   = den_mag[15:0];
        neg_nxt   = a_op[32] ^ b_op[17] ^ den_op[16];
        zero_nxt  = (den_op == '0);
        cnt_nxt   = '0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        mag_nxt = mag_t;
        rem_nxt = rem_t;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = BK_FIX;
        end else begin
          cnt_nxt = cnt_r + DIV_CNT_W'(1);
        end
      end
      BK_FIX: begin
        if (!axis_r) begin
          res_x_nxt = clamped;
          axis_nxt  = 1'b1;
          state_nxt = BK_MUL;
        end else begin
          res_y_nxt = clamped;
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          ov_nxt        = 1'b1;
          o_keypad_nxt  = 1'b0;
          o_pressed_nxt = job_r.pressed;
          o_x_nxt       = res_x_r;
          o_y_nxt       = res_y_r;
          o_key_nxt     = '0;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    axis_r      <= axis_nxt;
    mag_r       <= mag_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    neg_r       <= neg_nxt;
    zero_r      <= zero_nxt;
    cnt_r       <= cnt_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    o_keypad_r  <= o_keypad_nxt;
    o_pressed_r <= o_pressed_nxt;
    o_x_r       <= o_x_nxt;
    o_y_r       <= o_y_nxt;
    o_key_r     <= o_key_nxt;
  end

  assign out_valid     = ov_r;
  assign out_is_keypad = o_keypad_r;
  assign out_pressed   = o_pressed_r;
  assign out_point_x   = $signed(o_x_r);
  assign out_point_y   = $signed(o_y_r);
  assign out_key_code  = o_key_r;

endmodule

// ----- rtl/touch_event_to_calibrated_point.sv -----
`timescale 1ns / 1ps
// Touch event to calibrated point.
// Input channel (in_valid/in_stall): input events (in_func 0) and polls
// (in_func 1). An event updates the held position and button state at the
// transfer; a keypad key event or a pointer/keypad poll queues one result.
// Result channel (out_valid/out_stall): one registered result, held while
// out_stall is high; the front keeps taking items meanwhile until the
// two-entry job queue is full, which raises in_stall.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
// only while no result is pending.
// Processing: a key result or an uncalibrated point passes through the job
// queue and is then loaded into the output register. A calibrated point
// is popped from the queue, then per axis goes through a multiply step,
// the DIV_STEPS steps of the shared divider (4 quotient bits a cycle) and
// a clamp step, and is finally loaded into the output register. The back
// takes no further job until a calibrated point has been loaded; other
// items are taken one per cycle while the queue has room.
// Reset (rst_n low, synchronous) clears position, button, last key,
// configuration registers, queue and output valid.
module touch_event_to_calibrated_point (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [15:0]                   in_ev_type,
  input  logic [15:0]                   in_ev_code,
  input  logic signed [31:0]            in_ev_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_keypad,
  output logic                          out_pressed,
  output logic signed [31:0]            out_point_x,
  output logic signed [31:0]            out_point_y,
  output logic [7:0]                    out_key_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import tcp_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_LOW:    cfg_nxt.x_low       = cfg_data;
        CFG_X_HIGH:   cfg_nxt.x_high      = cfg_data;
        CFG_Y_LOW:    cfg_nxt.y_low       = cfg_data;
        CFG_Y_HIGH:   cfg_nxt.y_high      = cfg_data;
        CFG_SHIFT:    cfg_nxt.shift       = $signed(cfg_data);
        CFG_ROTATION: cfg_nxt.rotation    = cfg_data[1:0];
        CFG_DEVICE:   cfg_nxt.device_kind = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_ev_type  (in_ev_type),
    .in_ev_code  (in_ev_code),
    .in_ev_value (in_ev_value),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  tcp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  tcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_head        (q_head),
    .q_empty       (q_status.empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_keypad (out_is_keypad),
    .out_pressed   (out_pressed),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_key_code  (out_key_code)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("job queue both full and empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("push into full job queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty job queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_keypad) |-> (out_point_x == 32'sd0 && out_point_y == 32'sd0))
    else $error("key result carries a point");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_keypad) |-> (out_key_code == 8'd0))
    else $error("pointer result carries a key code");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import tcp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 98;

  localparam logic [1:0] ROT_SPARE = 2'd3;
  localparam logic [1:0] DEV_OTHER = 2'd2;
  localparam logic [1:0] DEV_SPARE = 2'd3;

  localparam logic [15:0] SCAN_ERASE  = 16'd14;
  localparam logic [15:0] SCAN_RETURN = 16'd28;
  localparam logic [15:0] SCAN_UP     = 16'd103;
  localparam logic [15:0] SCAN_WEST   = 16'd105;
  localparam logic [15:0] SCAN_EAST   = 16'd106;
  localparam logic [15:0] SCAN_SOUTH  = 16'd108;

  localparam logic [7:0] NAV_NONE      = 8'd0;
  localparam logic [7:0] NAV_BACKSPACE = 8'd8;
  localparam logic [7:0] NAV_NEXT      = 8'd9;
  localparam logic [7:0] NAV_ENTER     = 8'd10;
  localparam logic [7:0] NAV_PREV      = 8'd11;
  localparam logic [7:0] NAV_UP        = 8'd17;
  localparam logic [7:0] NAV_DOWN      = 8'd18;

  typedef struct packed {
    logic               is_keypad;
    logic               pressed;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         key_code;
  } touch_report_t;

  class point_tracker;
    logic [15:0]        x_low, x_high, y_low, y_high;
    logic signed [15:0] shift;
    logic [1:0]         rotation, device;
    logic [31:0]        pos_x, pos_y;
    logic               button;
    logic [7:0]         key;
    touch_report_t      queued_reports[$];
    int                 errors;

    function new();
      x_low    = '0;
      x_high   = '0;
      y_low    = '0;
      y_high   = '0;
      shift    = '0;
      rotation = ROT_NONE;
      device   = DEV_POINTER;
      pos_x    = '0;
      pos_y    = '0;
      button   = 1'b0;
      key      = NAV_NONE;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_X_LOW:    x_low = data;
        CFG_X_HIGH:   x_high = data;
        CFG_Y_LOW:    y_low = data;
        CFG_Y_HIGH:   y_high = data;
        CFG_SHIFT:    shift = data;
        CFG_ROTATION: rotation = data[1:0];
        CFG_DEVICE:   device = data[1:0];
        default: ;
      endcase
    endfunction

    // most negative value maps to itself
    function logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? -v : v;
    endfunction

    function logic [7:0] nav_code(logic [15:0] code);
      case (code)
        SCAN_ERASE:  return NAV_BACKSPACE;
        SCAN_RETURN: return NAV_ENTER;
        SCAN_UP:     return NAV_UP;
        SCAN_WEST:   return NAV_PREV;
        SCAN_EAST:   return NAV_NEXT;
        SCAN_SOUTH:  return NAV_DOWN;
        default:     return NAV_NONE;
      endcase
    endfunction

    function longint map_axis(longint v, longint in_lo, longint in_hi, longint out_lo,
                              longint out_hi);
      longint span;
      span = in_hi - in_lo;
      if (span == 0) return out_lo;
      return (v - in_lo) * (out_hi - out_lo) / span + out_lo;
    endfunction

    function longint clip(longint v, longint size);
      if (v < 0) return 0;
      if (v >= size) return size - 1;
      return v;
    endfunction

    function touch_report_t pointer_report();
      logic [31:0]   px, py;
      longint        x, y, lo, hi, shift_w;
      touch_report_t r;
      case (rotation)
        ROT_90: begin
          px = pos_y;
          py = magnitude(RAW_WIDTH_W - pos_x);
        end
        ROT_270: begin
          px = pos_y;
          py = pos_x;
        end
        default: begin
          px = pos_x;
          py = pos_y;
        end
      endcase
      x = longint'($signed(px));
      y = longint'($signed(py));
      if (x_low != 0 && x_high != 0 && y_low != 0 && y_high != 0) begin
        shift_w = shift;
        lo = x_low;
        hi = x_high;
        x = clip(map_axis(x, lo, hi, shift_w, DISP_WIDTH), DISP_WIDTH);
        lo = y_low;
        hi = y_high;
        y = clip(map_axis(y, lo + shift_w, hi + shift_w, 0, DISP_HEIGHT), DISP_HEIGHT);
      end
      r = '0;
      r.pressed = button;
      r.point_x = x[31:0];
      r.point_y = y[31:0];
      return r;
    endfunction

    function touch_report_t key_report();
      touch_report_t r;
      r = '0;
      r.is_keypad = 1'b1;
      r.pressed = button;
      r.key_code = key;
      return r;
    endfunction

    function void take_input(logic func, logic [15:0] ev_type, logic [15:0] ev_code,
                             logic [31:0] value);
      if (func == FUNC_EVENT) begin
        case (ev_type)
          EV_REL: begin
            if (ev_code == CODE_X) pos_x += value;
            else if (ev_code == CODE_Y) pos_y += magnitude(value + Y_BIAS_W);
          end
          EV_ABS: begin
            if (ev_code == CODE_X || ev_code == CODE_MT_X) pos_x = value;
            else if (ev_code == CODE_Y || ev_code == CODE_MT_Y) pos_y = magnitude(value + Y_BIAS_W);
          end
          EV_KEY: begin
            if (ev_code == CODE_BTN_MOUSE || ev_code == CODE_BTN_TOUCH) begin
              if (value == 0) button = 1'b0;
              else if (value == 1) button = 1'b1;
            end else if (device == DEV_KEYPAD) begin
              button = (value != 0);
              key = nav_code(ev_code);
              queued_reports.push_back(key_report());
            end
          end
          default: ;
        endcase
      end else if (device == DEV_KEYPAD) begin
        queued_reports.push_back(key_report());
      end else if (device == DEV_POINTER) begin
        queued_reports.push_back(pointer_report());
      end
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(touch_report_t got);
      touch_report_t want;
      if (queued_reports.size() == 0) begin
        $error("result transfer with no result pending");
        errors++;
        return;
      end
      want = queued_reports.pop_front();
      compare("is_keypad", want.is_keypad, got.is_keypad);
      compare("pressed", want.pressed, got.pressed);
      compare("point_x", want.point_x, got.point_x);
      compare("point_y", want.point_y, got.point_y);
      compare("key_code", want.key_code, got.key_code);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_func;
  logic [15:0]          in_ev_type;
  logic [15:0]          in_ev_code;
  logic signed [31:0]   in_ev_value;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_is_keypad;
  logic                 out_pressed;
  logic signed [31:0]   out_point_x;
  logic signed [31:0]   out_point_y;
  logic [7:0]           out_key_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  bit            quiet;
  point_tracker  tracker;
  touch_report_t seen_report;

  touch_event_to_calibrated_point DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_report.is_keypad = out_is_keypad;
      seen_report.pressed   = out_pressed;
      seen_report.point_x   = out_point_x;
      seen_report.point_y   = out_point_y;
      seen_report.key_code  = out_key_code;
      tracker.check_report(seen_report);
    end
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(logic func, logic [15:0] ev_type, logic [15:0] ev_code,
                           logic [31:0] value);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_ev_type  <= ev_type;
    in_ev_code  <= ev_code;
    in_ev_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_input(func, ev_type, ev_code, value);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_setup(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                            logic [15:0] yh, logic [15:0] sh, logic [1:0] rot,
                            logic [1:0] dev);
    write_reg(CFG_X_LOW, xl);
    write_reg(CFG_X_HIGH, xh);
    write_reg(CFG_Y_LOW, yl);
    write_reg(CFG_Y_HIGH, yh);
    write_reg(CFG_SHIFT, sh);
    write_reg(CFG_ROTATION, {14'd0, rot});
    write_reg(CFG_DEVICE, {14'd0, dev});
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every pending result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.queued_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [15:0] cal[4];
    logic [15:0] sh;
    logic [1:0]  dev;
    int          mode;
    int          pick;
    mode = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0: cal[i] = (i == 2) ? 16'd0 : 16'($urandom);
        1: cal[i] = (i % 2 == 0) ? 16'($urandom_range(1, 400)) : 16'($urandom_range(3000, 4095));
        2: cal[i] = 16'($urandom);
        default: cal[i] = $urandom_range(1) ? 16'hFFFF : 16'd1;
      endcase
    end
    case ($urandom_range(4))
      0: sh = 16'h8000;
      1: sh = 16'h7FFF;
      2: sh = 16'd0;
      3: sh = 16'($urandom_range(400) - 200);
      default: sh = 16'($urandom);
    endcase
    pick = $urandom_range(19);
    if (pick < 9) dev = DEV_POINTER;
    else if (pick < 16) dev = DEV_KEYPAD;
    else if (pick < 18) dev = DEV_OTHER;
    else dev = DEV_SPARE;
    load_setup(cal[0], cal[1], cal[2], cal[3], sh, 2'($urandom_range(3)), dev);
  endtask

  task automatic random_item();
    logic [31:0] value;
    logic [15:0] code;
    int          pick;
    pick = $urandom_range(99);
    value = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4095);
    if (pick < 22) begin
      send_item(FUNC_POLL, 16'($urandom), 16'($urandom), $urandom);
    end else if (pick < 42) begin
      case ($urandom_range(3))
        0: code = CODE_X;
        1: code = CODE_Y;
        2: code = CODE_MT_X;
        default: code = CODE_MT_Y;
      endcase
      send_item(FUNC_EVENT, EV_ABS, code, value);
    end else if (pick < 57) begin
      if ($urandom_range(9) != 0) value = $urandom_range(200) - 100;
      send_item(FUNC_EVENT, EV_REL, $urandom_range(1) ? CODE_X : CODE_Y, value);
    end else if (pick < 70) begin
      case ($urandom_range(4))
        0, 1: value = 32'd0;
        2, 3: value = 32'd1;
        default: value = $urandom;
      endcase
      send_item(FUNC_EVENT, EV_KEY, $urandom_range(1) ? CODE_BTN_MOUSE : CODE_BTN_TOUCH, value);
    end else if (pick < 88) begin
      case ($urandom_range(7))
        0: code = SCAN_ERASE;
        1: code = SCAN_RETURN;
        2: code = SCAN_UP;
        3: code = SCAN_WEST;
        4: code = SCAN_EAST;
        5: code = SCAN_SOUTH;
        6: code = 16'($urandom);
        default: code = 16'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: value = 32'd0;
        1: value = 32'd1;
        2: value = 32'd2;
        default: value = $urandom;
      endcase
      send_item(FUNC_EVENT, EV_KEY, code, value);
    end else begin
      send_item(FUNC_EVENT, $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4)),
                16'($urandom), $urandom);
    end
  endtask

  initial begin
    tracker     = new();
    quiet       = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FUNC_EVENT;
    in_ev_type  = '0;
    in_ev_code  = '0;
    in_ev_value = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_X_LOW;
    cfg_data    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // pointer mode, no calibration
    load_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, ROT_NONE, DEV_POINTER);
    send_item(FUNC_EVENT, EV_ABS, CODE_X, 32'h7FFF_FFFF);
    send_item(FUNC_EVENT, EV_ABS, CODE_Y, 32'h8000_0000);
    send_item(FUNC_POLL, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(FUNC_EVENT, EV_REL, CODE_X, 32'd1);
    send_item(FUNC_EVENT, EV_REL, CODE_Y, -32'sd5);
    send_item(FUNC_EVENT, EV_KEY, CODE_BTN_MOUSE, 32'd1);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);
    send_item(FUNC_EVENT, EV_ABS, CODE_MT_X, 32'hFFFF_FFFF);
    send_item(FUNC_EVENT, EV_ABS, CODE_MT_Y, 32'd7);
    send_item(FUNC_EVENT, EV_KEY, CODE_BTN_TOUCH, 32'd2);
    send_item(FUNC_EVENT, EV_KEY, SCAN_RETURN, 32'd1);
    send_item(FUNC_EVENT, 16'hFFFF, 16'hFFFF, 32'h5A5A_A5A5);
    send_item(FUNC_EVENT, EV_KEY, CODE_BTN_TOUCH, 32'd0);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);

    // calibrated, rotate 90
    drain();
    load_setup(16'd100, 16'd3900, 16'd200, 16'd3800, 16'h8000, ROT_90, DEV_POINTER);
    send_item(FUNC_EVENT, EV_ABS, CODE_X, 32'd500);
    send_item(FUNC_EVENT, EV_ABS, CODE_Y, 32'd1000);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);

    // zero span on both axes, spare rotation
    drain();
    load_setup(16'd5, 16'd5, 16'd9, 16'd9, 16'h7FFF, ROT_SPARE, DEV_POINTER);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);

    drain();
    load_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, ROT_270, DEV_KEYPAD);
    send_item(FUNC_EVENT, EV_KEY, SCAN_ERASE, 32'd1);
    send_item(FUNC_EVENT, EV_KEY, SCAN_UP, 32'hFFFF_FFFF);
    send_item(FUNC_EVENT, EV_KEY, SCAN_WEST, 32'd0);
    send_item(FUNC_EVENT, EV_KEY, 16'd999, 32'd1);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);

    drain();
    load_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, ROT_NONE, DEV_OTHER);
    send_item(FUNC_EVENT, EV_KEY, SCAN_SOUTH, 32'd1);
    send_item(FUNC_POLL, 16'd0, 16'd0, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      random_setup();
      quiet = (p == 4 || p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        random_item();
      end
    end
    quiet = 1'b0;
    drain();

    if (tracker.errors == 0 && tracker.queued_reports.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
